[src/hci_h4_packet_reassembler_defines.svh]
// Assertion macros shared by the H4 reassembler RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef HCI_H4_PACKET_REASSEMBLER_DEFINES_SVH
`define HCI_H4_PACKET_REASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HHR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define HHR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define HHR_ASSERT_NOW(lbl, pre, post, msg)
`define HHR_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[src/hhr_pkg.sv]
// Types and constants for the H4 packet reassembler.
// No dependencies; used by every other file but the assertion macro header.
`timescale 1ns / 1ps

package hhr_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 17;
  localparam int SHORT_W    = 9;
  localparam int KIND_W     = 2;
  localparam int PTYPE_W    = 2;
  localparam int HDR_DEPTH  = 4;
  localparam int HDR_IDX_W  = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // packet indicators
  localparam logic [DATA_W-1:0] IND_EVENT = 8'h04;
  localparam logic [DATA_W-1:0] IND_ACL   = 8'h02;
  localparam logic [DATA_W-1:0] IND_SCO   = 8'h03;

  // header bytes needed before the length is known
  localparam logic [LEN_W-1:0] HDR_LEN_EVT = 17'd2;
  localparam logic [LEN_W-1:0] HDR_LEN_SCO = 17'd3;
  localparam logic [LEN_W-1:0] HDR_LEN_ACL = 17'd4;

  // length field to packet length, indicator included
  localparam logic [LEN_W-1:0] LEN_ADJ_EVT = 17'd3;
  localparam logic [LEN_W-1:0] LEN_ADJ_ACL = 17'd5;
  localparam logic [LEN_W-1:0] LEN_ADJ_SCO = 17'd4;

  localparam logic [SHORT_W-1:0] EVENT_MAX_RST = 9'd258;
  localparam logic [LEN_W-1:0]   ACL_MAX_RST   = 17'd1029;
  localparam logic [SHORT_W-1:0] SCO_MAX_RST   = 9'd259;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_UNKNOWN  = 2'd2
  } kind_t;

  typedef enum logic [PTYPE_W-1:0] {
    PT_EVENT = 2'd0,
    PT_ACL   = 2'd1,
    PT_SCO   = 2'd2
  } ptype_t;

  typedef enum logic [1:0] {
    REG_EVENT_MAX = 2'd0,
    REG_ACL_MAX   = 2'd1,
    REG_SCO_MAX   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SHORT_W-1:0] event_max;
    logic [LEN_W-1:0]   acl_max;
    logic [SHORT_W-1:0] sco_max;
  } cfg_t;

  // One queue entry: one to four results from one input byte.
  typedef struct packed {
    kind_t                              kind;
    ptype_t                             ptype;
    logic [HDR_IDX_W-1:0]               last_idx;
    logic                               plast;
    logic [HDR_DEPTH-1:0][DATA_W-1:0]   bytes;
  } entry_t;

endpackage

[src/hhr_if.sv]
// Valid/ready channel interfaces for the H4 reassembler byte input and results.
// Depends on hhr_pkg.
`timescale 1ns / 1ps

interface hhr_in_if;
  logic                      valid;
  logic                      ready;
  logic [hhr_pkg::DATA_W-1:0] data_byte;
  logic                      chunk_last;

  modport source (output valid, data_byte, chunk_last, input ready);
  modport sink   (input valid, data_byte, chunk_last, output ready);
endinterface

interface hhr_out_if;
  logic                       valid;
  logic                       ready;
  logic [hhr_pkg::KIND_W-1:0]  kind;
  logic [hhr_pkg::PTYPE_W-1:0] pkt_type;
  logic [hhr_pkg::DATA_W-1:0]  out_byte;
  logic                       packet_last;
  logic                       run_last;

  modport source (output valid, kind, pkt_type, out_byte, packet_last, run_last,
                  input ready);
  modport sink   (input valid, kind, pkt_type, out_byte, packet_last, run_last,
                  output ready);
endinterface

[src/hhr_regs.sv]
// APB-style configuration registers: per-type maximum packet lengths.
// Depends on hhr_pkg.
`timescale 1ns / 1ps

module hhr_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hhr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hhr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hhr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output hhr_pkg::cfg_t                   cfg
);

  hhr_pkg::cfg_t     cfg_r;
  hhr_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = hhr_pkg::reg_idx_t'(paddr[hhr_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.event_max <= hhr_pkg::EVENT_MAX_RST;
      cfg_r.acl_max   <= hhr_pkg::ACL_MAX_RST;
      cfg_r.sco_max   <= hhr_pkg::SCO_MAX_RST;
    end else if (wr_en) begin
      case (idx)
        hhr_pkg::REG_EVENT_MAX: cfg_r.event_max <= pwdata[hhr_pkg::SHORT_W-1:0];
        hhr_pkg::REG_ACL_MAX:   cfg_r.acl_max   <= pwdata[hhr_pkg::LEN_W-1:0];
        hhr_pkg::REG_SCO_MAX:   cfg_r.sco_max   <= pwdata[hhr_pkg::SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      hhr_pkg::REG_EVENT_MAX:
        prdata = hhr_pkg::APB_DATA_W'(cfg_r.event_max);
      hhr_pkg::REG_ACL_MAX:
        prdata = hhr_pkg::APB_DATA_W'(cfg_r.acl_max);
      hhr_pkg::REG_SCO_MAX:
        prdata = hhr_pkg::APB_DATA_W'(cfg_r.sco_max);
      default: prdata = '0;
    endcase
  end

endmodule

[src/hhr_front.sv]
// Front end: H4 byte parser. Tracks indicator, header, payload and drop
// phases and pushes one result entry per byte that yields results.
// Depends on hhr_pkg, hhr_if and the assertion macro header.
`timescale 1ns / 1ps
`include "hci_h4_packet_reassembler_defines.svh"

module hhr_front (
  input  logic            clk,
  input  logic            rst_n,
  hhr_in_if.sink          in_ch,
  input  hhr_pkg::cfg_t   cfg,
  input  logic            push_ready,
  output logic            push_valid,
  output hhr_pkg::entry_t push_data
);

  typedef enum logic [1:0] {
    S_IND,
    S_HDR,
    S_BODY,
    S_DROP
  } state_t;

  localparam int LW = hhr_pkg::LEN_W;
  localparam int DW = hhr_pkg::DATA_W;

  state_t                                     state_r, state_nxt;
  hhr_pkg::ptype_t                            type_r, type_nxt;
  logic [LW-1:0]                              bc_r, bc_nxt;
  logic [LW-1:0]                              target_r, target_nxt;
  logic [hhr_pkg::HDR_DEPTH-1:0][DW-1:0]      hdr_r, hdr_nxt;

  logic                                       fire;
  logic [DW-1:0]                              b;
  logic                                       clast;
  logic [LW-1:0]                              bc_inc;
  logic [hhr_pkg::HDR_IDX_W-1:0]              hdr_idx;
  logic [hhr_pkg::HDR_DEPTH-1:0][DW-1:0]      hdr_new;
  logic                                       len_known;
  logic [LW-1:0]                              len;
  logic [LW-1:0]                              max_len;

  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid && push_ready;
  assign b           = in_ch.data_byte;
  assign clast       = in_ch.chunk_last;
  assign bc_inc      = bc_r + LW'(1);
  // header byte k (1..4) goes to slot k-1
  assign hdr_idx     = bc_r[hhr_pkg::HDR_IDX_W-1:0] - hhr_pkg::HDR_IDX_W'(1);

  always_comb begin
    for (int k = 0; k < hhr_pkg::HDR_DEPTH; k++) begin
      hdr_new[k] = (hhr_pkg::HDR_IDX_W'(k) == hdr_idx) ? b : hdr_r[k];
    end
  end

  always_comb begin
    len_known = 1'b0;
    len       = '0;
    max_len   = '0;
    case (type_r)
      hhr_pkg::PT_EVENT: begin
        len_known = bc_inc > hhr_pkg::HDR_LEN_EVT;
        len       = LW'(hdr_new[1]) + hhr_pkg::LEN_ADJ_EVT;
        max_len   = LW'(cfg.event_max);
      end
      hhr_pkg::PT_ACL: begin
        len_known = bc_inc > hhr_pkg::HDR_LEN_ACL;
        len       = LW'({hdr_new[3], hdr_new[2]}) + hhr_pkg::LEN_ADJ_ACL;
        max_len   = cfg.acl_max;
      end
      hhr_pkg::PT_SCO: begin
        len_known = bc_inc > hhr_pkg::HDR_LEN_SCO;
        len       = LW'(hdr_new[2]) + hhr_pkg::LEN_ADJ_SCO;
        max_len   = LW'(cfg.sco_max);
      end
      default: begin
        len_known = 1'b0;
        len       = '0;
        max_len   = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    type_nxt   = type_r;
    bc_nxt     = bc_r;
    target_nxt = target_r;
    hdr_nxt    = hdr_r;
    push_valid = 1'b0;
    push_data  = '0;
    push_data.kind  = hhr_pkg::KIND_BYTE;
    push_data.ptype = type_r;

    case (state_r)
      S_IND: begin
        if (fire) begin
          bc_nxt     = LW'(1);
          target_nxt = '0;
          case (b)
            hhr_pkg::IND_EVENT: begin
              type_nxt  = hhr_pkg::PT_EVENT;
              state_nxt = S_HDR;
            end
            hhr_pkg::IND_ACL: begin
              type_nxt  = hhr_pkg::PT_ACL;
              state_nxt = S_HDR;
            end
            hhr_pkg::IND_SCO: begin
              type_nxt  = hhr_pkg::PT_SCO;
              state_nxt = S_HDR;
            end
            default: begin
              push_valid         = 1'b1;
              push_data.kind     = hhr_pkg::KIND_UNKNOWN;
              push_data.ptype    = hhr_pkg::PT_EVENT;
              push_data.bytes[0] = b;
              state_nxt          = clast ? S_IND : S_DROP;
            end
          endcase
        end
      end

      S_HDR: begin
        if (fire) begin
          hdr_nxt = hdr_new;
          bc_nxt  = bc_inc;
          if (len_known) begin
            push_valid = 1'b1;
            if (len > max_len) begin
              push_data.kind = hhr_pkg::KIND_OVERSIZE;
              bc_nxt         = LW'(1);
              state_nxt      = clast ? S_IND : S_DROP;
            end else begin
              // flush the held header; its last slot is the one just written
              push_data.bytes    = hdr_new;
              push_data.last_idx = hdr_idx;
              push_data.plast    = (bc_inc == len);
              if (bc_inc == len) begin
                bc_nxt    = LW'(1);
                state_nxt = S_IND;
              end else begin
                target_nxt = len;
                state_nxt  = S_BODY;
              end
            end
          end
        end
      end

      S_BODY: begin
        if (fire) begin
          push_valid         = 1'b1;
          push_data.bytes[0] = b;
          push_data.plast    = (bc_inc >= target_r);
          bc_nxt             = bc_inc;
          if (bc_inc >= target_r) begin
            bc_nxt     = LW'(1);
            target_nxt = '0;
            state_nxt  = S_IND;
          end
        end
      end

      S_DROP: begin
        if (fire && clast) begin
          state_nxt = S_IND;
        end
      end

      default: state_nxt = S_IND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IND;
      type_r   <= hhr_pkg::PT_EVENT;
      bc_r     <= LW'(1);
      target_r <= '0;
    end else begin
      state_r  <= state_nxt;
      type_r   <= type_nxt;
      bc_r     <= bc_nxt;
      target_r <= target_nxt;
    end
    hdr_r <= hdr_nxt;
  end

  `HHR_ASSERT_NOW(a_hdr_count, state_r == S_HDR, (bc_r >= LW'(1)) && (bc_r <= hhr_pkg::HDR_LEN_ACL), "header byte count out of range")
  `HHR_ASSERT_NOW(a_body_count, state_r == S_BODY, bc_r < target_r, "payload count reached target without closing the packet")
  `HHR_ASSERT_NEXT(a_drop_end, (state_r == S_DROP) && fire && clast, state_r == S_IND, "discard did not end on chunk end")

endmodule

[src/hhr_queue.sv]
// Short entry queue between the parser and the result serializer.
// Depends on hhr_pkg.
`timescale 1ns / 1ps

module hhr_queue #(
  parameter int DEPTH = hhr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  hhr_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output hhr_pkg::entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hhr_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/hhr_back.sv]
// Back end: holds one queue entry and hands out its one to four results.
// Depends on hhr_pkg, hhr_if and the assertion macro header.
`timescale 1ns / 1ps
`include "hci_h4_packet_reassembler_defines.svh"

module hhr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  hhr_pkg::entry_t pop_data,
  hhr_out_if.source       out_ch
);

  localparam int IW = hhr_pkg::HDR_IDX_W;

  hhr_pkg::entry_t cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            out_fire;
  logic            at_last;

  assign at_last   = (idx_r == cur_r.last_idx);
  assign out_fire  = out_ch.valid && out_ch.ready;
  // refill when empty or when the final result of the held entry leaves
  assign pop_ready = !cur_valid_r || (out_fire && at_last);

  assign out_ch.valid       = cur_valid_r;
  assign out_ch.kind        = cur_r.kind;
  assign out_ch.pkt_type    = cur_r.ptype;
  assign out_ch.out_byte    = cur_r.bytes[idx_r];
  assign out_ch.packet_last = cur_r.plast && at_last;
  assign out_ch.run_last    = at_last;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop_valid && pop_ready) begin
      cur_nxt       = pop_data;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (out_fire) begin
      if (at_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
    cur_r <= cur_nxt;
  end

  `HHR_ASSERT_NOW(a_idx_range, cur_valid_r, idx_r <= cur_r.last_idx, "result index past end of entry")
  `HHR_ASSERT_NEXT(a_stall_hold, cur_valid_r && !out_ch.ready, cur_valid_r && $stable(idx_r), "stalled result moved")
  `HHR_ASSERT_NOW(a_plast_run, cur_valid_r && out_ch.packet_last, out_ch.run_last && (cur_r.kind == hhr_pkg::KIND_BYTE), "packet end not on last byte result")

endmodule

[src/hci_h4_packet_reassembler.sv]
// H4 packet reassembler: one UART byte per cycle in, tagged packet bytes out.
// An accepted byte's results pass through the entry queue, then the result register.
// Throughput: one byte per cycle while the entry queue has room; a header flush holds the
// result port for two to four results, which the QUEUE_DEPTH-entry queue absorbs.
// Reset (rst_n, synchronous, active low): parser waits for an indicator, queue and result
// register empty, length limits back to 258 / 1029 / 259. No clearing pass.
`timescale 1ns / 1ps

module hci_h4_packet_reassembler #(
  parameter int QUEUE_DEPTH = hhr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hhr_in_if.sink                         in_ch,
  hhr_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hhr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hhr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hhr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // Config: max packet length per type, indicator included.
  hhr_pkg::cfg_t   cfg;

  // Front to queue: one entry per byte that yields results.
  logic            push_valid;
  logic            push_ready;
  hhr_pkg::entry_t push_data;

  // Queue to back end.
  logic            pop_valid;
  logic            pop_ready;
  hhr_pkg::entry_t pop_data;

  hhr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser: indicator decode, header hold, length check, payload count,
  // discard to end of chunk after an unknown indicator or an oversize length.
  hhr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Input stalls only when this queue is full.
  hhr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Serializer: unrolls a header flush into single results and marks
  // the result that closes each input's run.
  hhr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

[sim/hci_h4_packet_reassembler_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the H4 packet reassembler: directed and random UART byte
// streams with chunk marks, predicted by an in-bench H4 parser and checked per result.
// Needs hhr_pkg, the hhr_in_if / hhr_out_if interfaces and the reassembler RTL.

module hci_h4_packet_reassembler_test;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 31;      // chance per cycle that a side idles
  localparam int CHUNK_END_PCT = 15;      // chance that a packet byte closes a read chunk
  localparam int SETTLE_CYCLES = 8;       // settle time after the last result
  localparam int HOLD_CYCLES   = 240;     // one long output stall
  localparam int MAX_SHOWN     = 10;
  localparam int TIMEOUT_NS    = 4_000_000;

  localparam int DW  = hhr_pkg::DATA_W;
  localparam int LW  = hhr_pkg::LEN_W;
  localparam int SW  = hhr_pkg::SHORT_W;
  localparam int IW  = hhr_pkg::HDR_IDX_W;
  localparam int HD  = hhr_pkg::HDR_DEPTH;
  localparam int AW  = hhr_pkg::APB_ADDR_W;
  localparam int PDW = hhr_pkg::APB_DATA_W;

  // parser state code for "waiting for an indicator"; the others are ptype_t values
  localparam logic [1:0] NO_PACKET = 2'd3;

  // one UART byte as the sender offers it
  typedef struct packed {
    logic [DW-1:0] data;
    logic          last;
  } uart_byte_t;

  // one result of the block, in port order
  typedef struct packed {
    hhr_pkg::kind_t  kind;
    hhr_pkg::ptype_t ptype;
    logic [DW-1:0]   data;
    logic            plast;
    logic            rlast;
  } h4_out_t;

  logic           clk;
  logic           rst_n;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [AW-1:0]  paddr;
  logic [PDW-1:0] pwdata;
  logic [PDW-1:0] prdata;
  logic           pready;

  hhr_in_if  in_ch();
  hhr_out_if out_ch();

  hci_h4_packet_reassembler i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bytes waiting to be offered, and packet results the parser model says are due
  uart_byte_t uart_rx_q[$];
  h4_out_t    h4_out_q[$];

  // parser model state
  logic [1:0]     rx_type;
  logic [LW-1:0]  rx_count;     // bytes of the packet so far, indicator included
  logic [LW-1:0]  rx_target;    // packet length, zero while the header is short
  logic [DW-1:0]  rx_hdr [HD];
  logic           rx_skip;      // dropping bytes up to the chunk end

  // length limits as last written
  logic [SW-1:0]  lim_event;
  logic [LW-1:0]  lim_acl;
  logic [SW-1:0]  lim_sco;

  bit          calm;                // no idling on either side
  bit          hold_req;
  bit          hold_used;
  int unsigned hold_left;

  int unsigned queued_items;
  int unsigned bytes_taken;
  int unsigned n_results;
  int unsigned n_packets;
  int unsigned n_drops;
  int unsigned n_unknown;
  int unsigned err_count;

  h4_out_t seen_out;
  h4_out_t want_out;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  function automatic string fmt_out(h4_out_t r);
    return $sformatf("kind=%0d type=%0d byte=%02h plast=%b rlast=%b",
                     r.kind, r.ptype, r.data, r.plast, r.rlast);
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic back_to_idle();
    rx_type   = NO_PACKET;
    rx_count  = LW'(1);
    rx_target = '0;
  endtask

  // Parser model: consumes one accepted byte and queues the results it causes.
  task automatic reassemble_byte(logic [DW-1:0] b, logic chunk_end);
    logic [LW-1:0]   len;
    logic [LW-1:0]   lim;
    hhr_pkg::ptype_t pt;
    if (rx_skip) begin
      // only the chunk's final byte ends a discard
      if (chunk_end) rx_skip = 1'b0;
      return;
    end
    if (rx_type == NO_PACKET) begin
      case (b)
        hhr_pkg::IND_EVENT: rx_type = hhr_pkg::PT_EVENT;
        hhr_pkg::IND_ACL:   rx_type = hhr_pkg::PT_ACL;
        hhr_pkg::IND_SCO:   rx_type = hhr_pkg::PT_SCO;
        default: begin
          // bad indicator: report it, then drop the rest of the chunk
          h4_out_q.push_back(h4_out_t'{hhr_pkg::KIND_UNKNOWN, hhr_pkg::PT_EVENT, b,
                                       1'b0, 1'b1});
          rx_skip = !chunk_end;
        end
      endcase
      rx_count  = LW'(1);
      rx_target = '0;
      return;
    end
    pt = hhr_pkg::ptype_t'(rx_type);
    if (rx_target != 0) begin
      // payload streams straight through; chunk ends do not matter here
      rx_count = rx_count + 1'b1;
      h4_out_q.push_back(h4_out_t'{hhr_pkg::KIND_BYTE, pt, b, rx_count >= rx_target, 1'b1});
      if (rx_count >= rx_target) back_to_idle();
      return;
    end
    if (rx_count <= HD) rx_hdr[IW'(rx_count - 1'b1)] = b;
    rx_count = rx_count + 1'b1;
    // length field plus indicator and header: event +3, ACL +5, SCO +4
    case (pt)
      hhr_pkg::PT_EVENT: begin
        len = (rx_count > 2) ? LW'(rx_hdr[1]) + LW'(3) : '0;
        lim = LW'(lim_event);
      end
      hhr_pkg::PT_ACL: begin
        len = (rx_count > 4) ? LW'({rx_hdr[3], rx_hdr[2]}) + LW'(5) : '0;
        lim = lim_acl;
      end
      default: begin
        len = (rx_count > 3) ? LW'(rx_hdr[2]) + LW'(4) : '0;
        lim = LW'(lim_sco);
      end
    endcase
    if (len == 0) return;
    if (len > lim) begin
      h4_out_q.push_back(h4_out_t'{hhr_pkg::KIND_OVERSIZE, pt, 8'h00, 1'b0, 1'b1});
      back_to_idle();
      rx_skip = !chunk_end;
      return;
    end
    // length known: flush the held header in one burst
    rx_target = len;
    for (int i = 1; i < rx_count; i++)
      h4_out_q.push_back(h4_out_t'{hhr_pkg::KIND_BYTE, pt, rx_hdr[IW'(i - 1)],
                                   (i + 1 == rx_count) && (rx_count == len),
                                   i + 1 == rx_count});
    if (rx_count == len) back_to_idle();
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [DW-1:0] b, logic chunk_end);
    uart_rx_q.push_back(uart_byte_t'{b, chunk_end});
    queued_items++;
  endtask

  function automatic logic rand_chunk_end();
    return $urandom_range(99) < CHUNK_END_PCT;
  endfunction

  // junk the block should swallow, closed by a chunk end
  task automatic push_discard_tail();
    repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
    push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // One well-formed packet with random content. Accepted packets are kept short;
  // large length fields only survive where they get dropped as oversize.
  task automatic queue_packet(hhr_pkg::ptype_t pt, logic [15:0] len_field);
    logic [DW-1:0] hdr [HD];
    logic [DW-1:0] ind;
    int unsigned   n_hdr;
    int unsigned   total;
    int unsigned   lim;
    logic          chunk_end;
    foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
    case (pt)
      hhr_pkg::PT_EVENT: begin
        ind = hhr_pkg::IND_EVENT; n_hdr = 2; lim = 32'(lim_event); len_field[15:8] = '0;
      end
      hhr_pkg::PT_ACL: begin
        ind = hhr_pkg::IND_ACL; n_hdr = 4; lim = 32'(lim_acl);
      end
      default: begin
        ind = hhr_pkg::IND_SCO; n_hdr = 3; lim = 32'(lim_sco); len_field[15:8] = '0;
      end
    endcase
    // the length counts the indicator and the header
    total = len_field + n_hdr + 1;
    if (total <= lim && len_field > 24) begin
      len_field = 16'(len_field % 25);
      total = len_field + n_hdr + 1;
    end
    if (pt == hhr_pkg::PT_ACL) {hdr[3], hdr[2]} = len_field;
    else hdr[IW'(n_hdr - 1)] = len_field[7:0];
    push_byte(ind, rand_chunk_end());
    chunk_end = 1'b0;
    for (int i = 0; i < n_hdr; i++) begin
      chunk_end = rand_chunk_end();
      push_byte(hdr[IW'(i)], chunk_end);
    end
    if (total > lim) begin
      if (!chunk_end) push_discard_tail();
    end else begin
      repeat (total - n_hdr - 1) push_byte(8'($urandom_range(255)), rand_chunk_end());
    end
  endtask

  // a bad indicator, possibly followed by the rest of its chunk
  task automatic queue_garbage();
    logic [DW-1:0] b;
    logic          chunk_end;
    do b = 8'($urandom_range(255));
    while (b == hhr_pkg::IND_EVENT || b == hhr_pkg::IND_ACL || b == hhr_pkg::IND_SCO);
    chunk_end = $urandom_range(99) < 30;
    push_byte(b, chunk_end);
    if (!chunk_end) push_discard_tail();
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned     stop_at;
    int unsigned     len_field;
    int unsigned     r;
    hhr_pkg::ptype_t pt;
    stop_at = queued_items + n;
    while (queued_items < stop_at) begin
      if ($urandom_range(99) < 15) begin
        queue_garbage();
      end else begin
        pt = hhr_pkg::ptype_t'($urandom_range(2));
        r  = $urandom_range(99);
        if (r < 70) len_field = $urandom_range(6);
        else if (r < 90) len_field = $urandom_range(24, 7);
        else if (pt == hhr_pkg::PT_ACL) len_field = $urandom_range(16'hFFFF);
        else len_field = $urandom_range(255);
        queue_packet(pt, 16'(len_field));
      end
    end
  endtask

  // wait until every byte is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (uart_rx_q.size() != 0 || in_ch.valid || h4_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes it when pready is high
  task automatic write_limit(hhr_pkg::reg_idx_t idx, logic [PDW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hhr_pkg::REG_EVENT_MAX: lim_event = value[SW-1:0];
      hhr_pkg::REG_ACL_MAX:   lim_acl   = value[LW-1:0];
      default:                lim_sco   = value[SW-1:0];
    endcase
    @(negedge clk);
  endtask

  // New limits, then a random stream; optionally no idling plus one long output stall.
  task automatic limits_phase(logic [SW-1:0] ev_max, logic [LW-1:0] acl_max,
                              logic [SW-1:0] sco_max, int unsigned n,
                              bit quiet, bit squeeze);
    write_limit(hhr_pkg::REG_EVENT_MAX, PDW'(ev_max));
    write_limit(hhr_pkg::REG_ACL_MAX, PDW'(acl_max));
    write_limit(hhr_pkg::REG_SCO_MAX, PDW'(sco_max));
    calm = quiet;
    queue_random(n);
    if (squeeze) hold_req = 1'b1;
    wait_drained();
    calm = 1'b0;
  endtask

  // ------------------------------------------------------------------ driver
  // Predicts on acceptance, then offers the next byte or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reassemble_byte(in_ch.data_byte, in_ch.chunk_last);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (uart_rx_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= uart_rx_q[0].data;
          in_ch.chunk_last <= uart_rx_q[0].last;
          void'(uart_rx_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one-shot long stall of the result side, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_out = h4_out_t'{hhr_pkg::kind_t'(out_ch.kind),
                             hhr_pkg::ptype_t'(out_ch.pkt_type), out_ch.out_byte,
                             out_ch.packet_last, out_ch.run_last};
        n_results++;
        case (seen_out.kind)
          hhr_pkg::KIND_BYTE:     if (seen_out.plast) n_packets++;
          hhr_pkg::KIND_OVERSIZE: n_drops++;
          hhr_pkg::KIND_UNKNOWN:  n_unknown++;
          default: ;
        endcase
        if (h4_out_q.size() == 0) begin
          flag_error($sformatf("result with nothing pending: %s", fmt_out(seen_out)));
        end else begin
          want_out = h4_out_q.pop_front();
          if (seen_out !== want_out)
            flag_error($sformatf("result %0d: expected %s, got %s", n_results,
                                 fmt_out(want_out), fmt_out(seen_out)));
        end
      end
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.chunk_last = 1'b0;
    out_ch.ready     = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    lim_event        = hhr_pkg::EVENT_MAX_RST;
    lim_acl          = hhr_pkg::ACL_MAX_RST;
    lim_sco          = hhr_pkg::SCO_MAX_RST;
    rx_skip          = 1'b0;
    back_to_idle();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // event with no parameters: the whole packet leaves in the header flush
    push_byte(hhr_pkg::IND_EVENT, 1'b0);
    push_byte(8'h0E, 1'b0);
    push_byte(8'h00, 1'b1);
    // ACL with empty payload: four-result flush
    push_byte(hhr_pkg::IND_ACL, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h2F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    // SCO whose header straddles a chunk boundary, one payload byte
    push_byte(hhr_pkg::IND_SCO, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h5A, 1'b1);
    // bad indicator closing its chunk: nothing discarded
    push_byte(8'h05, 1'b1);
    // bad indicator mid-chunk: the rest of the chunk goes
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // ACL just over the reset limit mid-chunk, then a discarded tail
    push_byte(hhr_pkg::IND_ACL, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h7E, 1'b1);
    // largest ACL length word, its last byte ends the chunk: no discard
    push_byte(hhr_pkg::IND_ACL, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    queue_random(30);
    wait_drained();

    limits_phase(9'd4, 17'd6, 9'd5, 35, 1'b0, 1'b0);          // bottom of the range
    limits_phase(9'd258, 17'd65540, 9'd259, 55, 1'b1, 1'b1);  // top, no idling, stall
    limits_phase(9'd2, 17'd3, 9'd0, 20, 1'b0, 1'b0);          // below range: all dropped
    limits_phase(9'd30, 17'd1000, 9'd40, 40, 1'b0, 1'b0);

    $display("Took %0d UART bytes and checked %0d results: %0d packets closed,",
             bytes_taken, n_results, n_packets);
    $display("%0d oversize drops, %0d bad indicators, over five limit settings.",
             n_drops, n_unknown);
    if (err_count == 0 && h4_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("FAILURE");
    $finish;
  end

endmodule
